### sv/mcpq_pkg.sv
// ----------------------------------------------------------------------------
// mcpq_pkg: shared types and constants
// Commands, result status codes, cell operations and control states for the
// multi-class max-priority queue.
// ----------------------------------------------------------------------------
`default_nettype none
package mcpq_pkg;

  localparam int CMD_W    = 2;
  localparam int DEPT_W   = 16;
  localparam int ID_W     = 32;
  localparam int INC_W    = 32;
  localparam int STATUS_W = 3;

  // a listing reports at most this many entries
  localparam int MAX_RESULTS = 32;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POP    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LIST   = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DUP    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NODEPT = 3'd4;

  // operation applied to every cell of the chain at once
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_POP,
    OP_ROTATE
  } cell_op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DUP,
    S_INS,
    S_POP,
    S_LFIND,
    S_LIST
  } state_t;

endpackage
`default_nettype wire

### sv/mcpq_cell.sv
// ----------------------------------------------------------------------------
// mcpq_cell: one slot of the sorted entry chain
// Holds one entry (id, income, run tag). Shifts right on insert, left on pop
// and rotate, and flags whether a new entry sorts in front of it.
// ----------------------------------------------------------------------------
`default_nettype none
module mcpq_cell
  import mcpq_pkg::*;
#(
  parameter int RW = 3
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  cell_op_t              op,
  // new entry and duplicate key
  input  wire logic [ID_W-1:0]  new_id,
  input  wire logic [INC_W-1:0] new_inc,
  input  wire logic [RW-1:0]    new_run,
  // left neighbor (toward the head)
  input  wire logic             lft_valid,
  input  wire logic [ID_W-1:0]  lft_id,
  input  wire logic [INC_W-1:0] lft_inc,
  input  wire logic [RW-1:0]    lft_run,
  input  wire logic             lft_ahead,
  // right neighbor (toward the tail)
  input  wire logic             rgt_valid,
  input  wire logic [ID_W-1:0]  rgt_id,
  input  wire logic [INC_W-1:0] rgt_inc,
  input  wire logic [RW-1:0]    rgt_run,
  // held entry
  output logic                  valid,
  output logic [ID_W-1:0]       id,
  output logic [INC_W-1:0]      inc,
  output logic [RW-1:0]         run,
  output logic                  ahead,
  output logic                  id_hit
);

  logic             valid_r, valid_nxt;
  logic [ID_W-1:0]  id_r, id_nxt;
  logic [INC_W-1:0] inc_r, inc_nxt;
  logic [RW-1:0]    run_r, run_nxt;

  // new entry goes in front: empty slot, higher income, or equal income and lower run
  assign ahead  = !valid_r || (new_inc > inc_r) || ((new_inc == inc_r) && (new_run < run_r));
  assign id_hit = valid_r && (id_r == new_id);

  assign valid = valid_r;
  assign id    = id_r;
  assign inc   = inc_r;
  assign run   = run_r;

  // next content
  always_comb begin
    valid_nxt = valid_r;
    id_nxt    = id_r;
    inc_nxt   = inc_r;
    run_nxt   = run_r;
    case (op)
      OP_INSERT: begin
        if (ahead) begin
          if (lft_ahead) begin
            valid_nxt = lft_valid;
            id_nxt    = lft_id;
            inc_nxt   = lft_inc;
            run_nxt   = lft_run;
          end else begin
            valid_nxt = 1'b1;
            id_nxt    = new_id;
            inc_nxt   = new_inc;
            run_nxt   = new_run;
          end
        end
      end
      OP_POP, OP_ROTATE: begin
        valid_nxt = rgt_valid;
        id_nxt    = rgt_id;
        inc_nxt   = rgt_inc;
        run_nxt   = rgt_run;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    id_r  <= id_nxt;
    inc_r <= inc_nxt;
    run_r <= run_nxt;
  end

endmodule
`default_nettype wire

### sv/multi_class_max_priority_queue.sv
// Insert: the duplicate scan is registered, then the entry is sorted in.
// Pop: the head entry is removed and its result registered.
// List: the chain rotates once through the head.
// One transaction is worked at a time; output stall can hold any of them.
// Synchronous active-low reset empties the chain and closes all runs.
// ----------------------------------------------------------------------------
// multi_class_max_priority_queue: top level
// Per-department run table plus one chain of cells kept sorted by income,
// run index and arrival, serving insert, pop-max and list commands.
// ----------------------------------------------------------------------------
`default_nettype none
module multi_class_max_priority_queue
  import mcpq_pkg::*;
#(
  parameter int RUNS         = 8,
  parameter int RUN_CAPACITY = 32
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [CMD_W-1:0]    in_command,
  input  wire logic [DEPT_W-1:0]   in_dept_no,
  input  wire logic [ID_W-1:0]     in_emp_id,
  input  wire logic [INC_W-1:0]    in_income,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [STATUS_W-1:0]      out_status,
  output logic [DEPT_W-1:0]        out_dept,
  output logic [ID_W-1:0]          out_id,
  output logic [INC_W-1:0]         out_income,
  output logic                     out_last
);

  localparam int CELLS = RUNS * RUN_CAPACITY;
  localparam int RW    = $clog2(RUNS);
  localparam int CW    = $clog2(RUN_CAPACITY + 1);
  localparam int TW    = $clog2(RUN_CAPACITY + MAX_RESULTS + 1);
  localparam int PW    = $clog2(CELLS);

  state_t state_r, state_nxt;

  // latched transaction
  logic [DEPT_W-1:0] dept_r;
  logic [ID_W-1:0]   id_r;
  logic [INC_W-1:0]  inc_r;

  // run table
  logic              run_used_r  [RUNS];
  logic [DEPT_W-1:0] run_dept_r  [RUNS];
  logic [CW-1:0]     run_count_r [RUNS];

  // listing control
  logic [RW-1:0] lrun_r, lrun_nxt;
  logic [TW-1:0] ltotal_r, ltotal_nxt;
  logic [TW-1:0] lcnt_r, lcnt_nxt;
  logic [PW-1:0] rot_r, rot_nxt;

  // chain wiring
  cell_op_t         op;
  logic             c_valid  [CELLS];
  logic [ID_W-1:0]  c_id     [CELLS];
  logic [INC_W-1:0] c_inc    [CELLS];
  logic [RW-1:0]    c_run    [CELLS];
  logic             c_ahead  [CELLS];
  logic [CELLS-1:0] hit;
  logic [CELLS-1:0] hit_r;
  logic [RW-1:0]    ins_run;

  genvar g;
  generate
    for (g = 0; g < CELLS; g++) begin : g_cell
      localparam int L = (g == 0) ? 0 : g - 1;
      localparam int R = (g == CELLS - 1) ? 0 : g + 1;
      logic rgt_v;
      // tail refills from the head on rotate, empties on pop
      assign rgt_v = (g == CELLS - 1) ? (c_valid[0] && (op == OP_ROTATE)) : c_valid[R];
      mcpq_cell #(.RW(RW)) u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .op         (op),
        .new_id     (id_r),
        .new_inc    (inc_r),
        .new_run    (ins_run),
        .lft_valid  (c_valid[L]),
        .lft_id     (c_id[L]),
        .lft_inc    (c_inc[L]),
        .lft_run    (c_run[L]),
        .lft_ahead  ((g == 0) ? 1'b0 : c_ahead[L]),
        .rgt_valid  (rgt_v),
        .rgt_id     (c_id[R]),
        .rgt_inc    (c_inc[R]),
        .rgt_run    (c_run[R]),
        .valid      (c_valid[g]),
        .id         (c_id[g]),
        .inc        (c_inc[g]),
        .run        (c_run[g]),
        .ahead      (c_ahead[g]),
        .id_hit     (hit[g])
      );
    end
  endgenerate

  // run lookup: lowest open run of the department, lowest free slot
  logic          dm_found, fr_found;
  logic [RW-1:0] dm_run, fr_run;
  always_comb begin
    dm_found = 1'b0;
    fr_found = 1'b0;
    dm_run   = '0;
    fr_run   = '0;
    for (int i = RUNS - 1; i >= 0; i--) begin
      if (run_used_r[i] && (run_dept_r[i] == dept_r)) begin
        dm_found = 1'b1;
        dm_run   = RW'(i);
      end
      if (!run_used_r[i]) begin
        fr_found = 1'b1;
        fr_run   = RW'(i);
      end
    end
  end

  logic dm_full;
  assign dm_full = (run_count_r[dm_run] >= CW'(RUN_CAPACITY));
  assign ins_run = dm_found ? dm_run : fr_run;

  // output register handshake
  logic out_valid_r;
  logic out_free;
  assign out_free = !out_valid_r || !out_stall;

  logic                emit;
  logic [STATUS_W-1:0] e_status;
  logic [DEPT_W-1:0]   e_dept;
  logic [ID_W-1:0]     e_id;
  logic [INC_W-1:0]    e_inc;
  logic                e_last;

  // table update requests
  logic          tb_ins, tb_open, tb_pop;
  logic [RW-1:0] pop_run;
  assign pop_run = c_run[0];

  logic head_hit;
  assign head_hit = c_valid[0] && (c_run[0] == lrun_r);

  // next state and outputs
  always_comb begin
    state_nxt  = state_r;
    op         = OP_HOLD;
    emit       = 1'b0;
    e_status   = ST_OK;
    e_dept     = '0;
    e_id       = '0;
    e_inc      = '0;
    e_last     = 1'b1;
    tb_ins     = 1'b0;
    tb_open    = 1'b0;
    tb_pop     = 1'b0;
    lrun_nxt   = lrun_r;
    ltotal_nxt = ltotal_r;
    lcnt_nxt   = lcnt_r;
    rot_nxt    = rot_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (in_command)
            CMD_INSERT: state_nxt = S_DUP;
            CMD_POP:    state_nxt = S_POP;
            CMD_LIST:   state_nxt = S_LFIND;
            default:    state_nxt = S_IDLE;
          endcase
        end
      end
      S_DUP: begin
        state_nxt = S_INS;
      end
      S_INS: begin
        if (out_free) begin
          emit      = 1'b1;
          state_nxt = S_IDLE;
          if (|hit_r) begin
            e_status = ST_DUP;
          end else if (dm_found) begin
            if (dm_full) begin
              e_status = ST_FULL;
            end else begin
              op     = OP_INSERT;
              tb_ins = 1'b1;
            end
          end else if (fr_found) begin
            op      = OP_INSERT;
            tb_open = 1'b1;
          end else begin
            e_status = ST_FULL;
          end
        end
      end
      S_POP: begin
        if (out_free) begin
          emit      = 1'b1;
          state_nxt = S_IDLE;
          if (c_valid[0]) begin
            op     = OP_POP;
            tb_pop = 1'b1;
            e_dept = run_dept_r[pop_run];
            e_id   = c_id[0];
            e_inc  = c_inc[0];
          end else begin
            e_status = ST_EMPTY;
          end
        end
      end
      S_LFIND: begin
        if (dm_found) begin
          lrun_nxt   = dm_run;
          ltotal_nxt = (TW'(run_count_r[dm_run]) > TW'(MAX_RESULTS)) ?
                       TW'(MAX_RESULTS) : TW'(run_count_r[dm_run]);
          lcnt_nxt   = '0;
          rot_nxt    = '0;
          state_nxt  = S_LIST;
        end else if (out_free) begin
          emit      = 1'b1;
          e_status  = ST_NODEPT;
          state_nxt = S_IDLE;
        end
      end
      S_LIST: begin
        // one rotation step per cycle when out_free; the head is reported if in the run
        if (out_free) begin
          op      = OP_ROTATE;
          rot_nxt = rot_r + PW'(1);
          if (head_hit && (lcnt_r < ltotal_r)) begin
            emit     = 1'b1;
            e_dept   = dept_r;
            e_id     = c_id[0];
            e_inc    = c_inc[0];
            e_last   = (lcnt_r + TW'(1) == ltotal_r);
            lcnt_nxt = lcnt_r + TW'(1);
          end
          if (rot_r == PW'(CELLS - 1)) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_stall = (state_r != S_IDLE);

  // state and transaction registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    if (state_r == S_IDLE && in_valid) begin
      dept_r <= in_dept_no;
      id_r   <= in_emp_id;
      inc_r  <= in_income;
    end
    hit_r    <= hit;
    lrun_r   <= lrun_nxt;
    ltotal_r <= ltotal_nxt;
    lcnt_r   <= lcnt_nxt;
    rot_r    <= rot_nxt;
  end

  // run table
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < RUNS; i++) begin
        run_used_r[i]  <= 1'b0;
        run_dept_r[i]  <= '0;
        run_count_r[i] <= '0;
      end
    end else begin
      if (tb_ins) begin
        run_count_r[dm_run] <= run_count_r[dm_run] + CW'(1);
      end
      if (tb_open) begin
        run_used_r[fr_run]  <= 1'b1;
        run_dept_r[fr_run]  <= dept_r;
        run_count_r[fr_run] <= CW'(1);
      end
      if (tb_pop) begin
        run_count_r[pop_run] <= run_count_r[pop_run] - CW'(1);
        if (run_count_r[pop_run] == CW'(1)) begin
          run_used_r[pop_run] <= 1'b0;
          run_dept_r[pop_run] <= '0;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (emit) begin
      out_status <= e_status;
      out_dept   <= e_dept;
      out_id     <= e_id;
      out_income <= e_inc;
      out_last   <= e_last;
    end
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire
